// File: rtl/nec_tx_pkg.sv
// nec_tx_pkg: shared types, register map and reset values for the nec ir frame transmitter
// used by nec_tx_regs, nec_tx_seq, nec_tx_obuf and nec_ir_frame_transmitter_top
package nec_tx_pkg;

    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 32;

    localparam int unsigned TICK_W  = 13;
    localparam int unsigned PULSE_W = 10;
    localparam int unsigned BIDX_W  = 6;
    localparam int unsigned FRAME_W = 32;

    localparam logic [BIDX_W-1:0] FRAME_BITS_TOTAL = 6'd32;

    typedef enum logic [2:0] {
        REG_CARRIER_HIGH = 3'd0,
        REG_CARRIER_LOW  = 3'd1,
        REG_HEADER_PULSE = 3'd2,
        REG_BIT_PULSE    = 3'd3,
        REG_HEADER_SPACE = 3'd4,
        REG_SHORT_SPACE  = 3'd5,
        REG_LONG_SPACE   = 3'd6
    } reg_idx_t;

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_HDR_BURST  = 7'b0000010,
        PH_HDR_SPACE  = 7'b0000100,
        PH_BIT_BURST  = 7'b0001000,
        PH_BIT_SPACE  = 7'b0010000,
        PH_STOP_BURST = 7'b0100000,
        PH_STOP_SPACE = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0]  carrier_high_ticks;
        logic [7:0]  carrier_low_ticks;
        logic [9:0]  header_pulses;
        logic [7:0]  bit_pulses;
        logic [12:0] header_space_ticks;
        logic [11:0] short_space_ticks;
        logic [11:0] long_space_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        carrier_high_ticks: 8'd12,
        carrier_low_ticks:  8'd12,
        header_pulses:      10'd342,
        bit_pulses:         8'd21,
        header_space_ticks: 13'd4500,
        short_space_ticks:  12'd562,
        long_space_ticks:   12'd1687
    };

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic frame_done;
        logic start_taken;
    } result_t;

endpackage

// File: rtl/nec_tx_regs.sv
// nec_tx_regs: apb-style timing register file
// depends on nec_tx_pkg
module nec_tx_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nec_tx_pkg::APB_AW-1:0]    paddr,
    input  logic [nec_tx_pkg::APB_DW-1:0]    pwdata,
    output logic [nec_tx_pkg::APB_DW-1:0]    prdata,
    output logic                             pready,
    output nec_tx_pkg::cfg_t                 cfg
);

    nec_tx_pkg::cfg_t     cfg_reg;
    nec_tx_pkg::cfg_t     cfg_next;
    nec_tx_pkg::reg_idx_t idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = nec_tx_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                nec_tx_pkg::REG_CARRIER_HIGH: cfg_next.carrier_high_ticks = pwdata[7:0];
                nec_tx_pkg::REG_CARRIER_LOW:  cfg_next.carrier_low_ticks  = pwdata[7:0];
                nec_tx_pkg::REG_HEADER_PULSE: cfg_next.header_pulses      = pwdata[9:0];
                nec_tx_pkg::REG_BIT_PULSE:    cfg_next.bit_pulses         = pwdata[7:0];
                nec_tx_pkg::REG_HEADER_SPACE: cfg_next.header_space_ticks = pwdata[12:0];
                nec_tx_pkg::REG_SHORT_SPACE:  cfg_next.short_space_ticks  = pwdata[11:0];
                nec_tx_pkg::REG_LONG_SPACE:   cfg_next.long_space_ticks   = pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            nec_tx_pkg::REG_CARRIER_HIGH: prdata = {24'd0, cfg_reg.carrier_high_ticks};
            nec_tx_pkg::REG_CARRIER_LOW:  prdata = {24'd0, cfg_reg.carrier_low_ticks};
            nec_tx_pkg::REG_HEADER_PULSE: prdata = {22'd0, cfg_reg.header_pulses};
            nec_tx_pkg::REG_BIT_PULSE:    prdata = {24'd0, cfg_reg.bit_pulses};
            nec_tx_pkg::REG_HEADER_SPACE: prdata = {19'd0, cfg_reg.header_space_ticks};
            nec_tx_pkg::REG_SHORT_SPACE:  prdata = {20'd0, cfg_reg.short_space_ticks};
            nec_tx_pkg::REG_LONG_SPACE:   prdata = {20'd0, cfg_reg.long_space_ticks};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= nec_tx_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/nec_tx_seq.sv
// nec_tx_seq: frame state and single-pass next-state logic, one request per cycle
// depends on nec_tx_pkg
module nec_tx_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  action,
    input  logic [15:0]           address,
    input  logic [7:0]            command,
    input  nec_tx_pkg::cfg_t      cfg,
    output nec_tx_pkg::result_t   res
);

    nec_tx_pkg::phase_t                  phase_reg, phase_next;
    logic [nec_tx_pkg::FRAME_W-1:0]      frame_reg, frame_next;
    logic [nec_tx_pkg::BIDX_W-1:0]       bidx_reg, bidx_next, bidx_inc;
    logic [nec_tx_pkg::PULSE_W-1:0]      pulse_reg, pulse_next, pulse_inc, pulse_lim;
    logic [nec_tx_pkg::TICK_W-1:0]       tick_reg, tick_next, tick_inc, space_lim;
    logic                                chh_reg, chh_next;
    logic                                in_burst, cur_bit, burst_end, space_end;
    logic                                done, taken, level;

    assign in_burst = (phase_reg == nec_tx_pkg::PH_HDR_BURST) ||
                      (phase_reg == nec_tx_pkg::PH_BIT_BURST) ||
                      (phase_reg == nec_tx_pkg::PH_STOP_BURST);
    assign tick_inc  = tick_reg + 1'b1;
    assign pulse_inc = pulse_reg + 1'b1;
    assign bidx_inc  = bidx_reg + 1'b1;
    assign cur_bit   = frame_reg[bidx_reg[4:0]];
    assign pulse_lim = (phase_reg == nec_tx_pkg::PH_HDR_BURST) ? cfg.header_pulses
                                                               : {2'd0, cfg.bit_pulses};

    always_comb
    begin
        case (phase_reg)
            nec_tx_pkg::PH_HDR_SPACE: space_lim = cfg.header_space_ticks;
            nec_tx_pkg::PH_BIT_SPACE: space_lim = cur_bit ? {1'b0, cfg.long_space_ticks}
                                                          : {1'b0, cfg.short_space_ticks};
            default:                  space_lim = {1'b0, cfg.short_space_ticks};
        endcase
    end

    assign space_end = (tick_inc >= space_lim);
    assign burst_end = !chh_reg && (tick_inc >= {5'd0, cfg.carrier_low_ticks})
                       && (pulse_inc >= pulse_lim);

    always_comb
    begin
        phase_next = phase_reg;
        frame_next = frame_reg;
        bidx_next  = bidx_reg;
        pulse_next = pulse_reg;
        tick_next  = tick_reg;
        chh_next   = chh_reg;
        done       = 1'b0;
        taken      = 1'b0;
        level      = in_burst && chh_reg;
        if (accept && action)
        begin
            if (phase_reg == nec_tx_pkg::PH_IDLE)
            begin
                frame_next = {~command, command, address};
                bidx_next  = '0;
                phase_next = nec_tx_pkg::PH_HDR_BURST;
                pulse_next = '0;
                tick_next  = '0;
                chh_next   = 1'b1;
                taken      = 1'b1;
                level      = 1'b1;
            end
        end
        else if (accept)
        begin
            case (phase_reg)
                nec_tx_pkg::PH_IDLE: ;
                nec_tx_pkg::PH_HDR_BURST,
                nec_tx_pkg::PH_BIT_BURST,
                nec_tx_pkg::PH_STOP_BURST:
                begin
                    tick_next = tick_inc;
                    if (chh_reg)
                    begin
                        if (tick_inc >= {5'd0, cfg.carrier_high_ticks})
                        begin
                            chh_next  = 1'b0;
                            tick_next = '0;
                        end
                    end
                    else if (tick_inc >= {5'd0, cfg.carrier_low_ticks})
                    begin
                        tick_next  = '0;
                        pulse_next = pulse_inc;
                        chh_next   = !burst_end;
                    end
                    if (burst_end)
                    begin
                        case (phase_reg)
                            nec_tx_pkg::PH_HDR_BURST: phase_next = nec_tx_pkg::PH_HDR_SPACE;
                            nec_tx_pkg::PH_BIT_BURST: phase_next = nec_tx_pkg::PH_BIT_SPACE;
                            default:                  phase_next = nec_tx_pkg::PH_STOP_SPACE;
                        endcase
                    end
                end
                nec_tx_pkg::PH_HDR_SPACE,
                nec_tx_pkg::PH_BIT_SPACE:
                begin
                    tick_next = tick_inc;
                    if (space_end)
                    begin
                        pulse_next = '0;
                        tick_next  = '0;
                        chh_next   = 1'b1;
                        phase_next = nec_tx_pkg::PH_BIT_BURST;
                        if (phase_reg == nec_tx_pkg::PH_BIT_SPACE)
                        begin
                            bidx_next = bidx_inc;
                            if (bidx_inc >= nec_tx_pkg::FRAME_BITS_TOTAL)
                            begin
                                phase_next = nec_tx_pkg::PH_STOP_BURST;
                            end
                        end
                    end
                end
                nec_tx_pkg::PH_STOP_SPACE:
                begin
                    tick_next = tick_inc;
                    if (space_end)
                    begin
                        phase_next = nec_tx_pkg::PH_IDLE;
                        tick_next  = '0;
                        pulse_next = '0;
                        chh_next   = 1'b0;
                        done       = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = nec_tx_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // tick: level of the current microsecond; accepted start: level of the new header
    assign res.pin_level   = level;
    assign res.busy_res    = (phase_next != nec_tx_pkg::PH_IDLE);
    assign res.frame_done  = done;
    assign res.start_taken = taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nec_tx_pkg::PH_IDLE;
            frame_reg <= '0;
            bidx_reg  <= '0;
            pulse_reg <= '0;
            tick_reg  <= '0;
            chh_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            frame_reg <= frame_next;
            bidx_reg  <= bidx_next;
            pulse_reg <= pulse_next;
            tick_reg  <= tick_next;
            chh_reg   <= chh_next;
        end
    end

    a_taken_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.start_taken |-> (res.busy_res && action && accept))
        else $error("start taken without entering a frame");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.frame_done |=> (phase_reg == nec_tx_pkg::PH_IDLE && tick_reg == '0
                            && pulse_reg == '0 && !chh_reg))
        else $error("frame end did not return to a clean idle state");

    a_start_header: assert property (@(posedge clk) disable iff (!rst_n)
        res.start_taken |=> (phase_reg == nec_tx_pkg::PH_HDR_BURST && chh_reg
                             && bidx_reg == '0))
        else $error("start did not open the header burst");

    a_bidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == nec_tx_pkg::PH_BIT_BURST || phase_reg == nec_tx_pkg::PH_BIT_SPACE)
        |-> !bidx_reg[5])
        else $error("bit index past the frame during a data bit");

endmodule

// File: rtl/nec_tx_obuf.sv
// nec_tx_obuf: two-entry result buffer (output register plus skid) with registered stall
// depends on nec_tx_pkg
module nec_tx_obuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  nec_tx_pkg::result_t   push_data,
    output logic                  full,
    output logic                  out_valid,
    input  logic                  out_stall,
    output nec_tx_pkg::result_t   out_data
);

    nec_tx_pkg::result_t head_reg, head_next, skid_reg, skid_next;
    logic                head_v_reg, head_v_next, skid_v_reg, skid_v_next;
    logic                pop, head_free;

    assign pop       = head_v_reg && !out_stall;
    assign head_free = !head_v_reg || pop;
    assign full      = skid_v_reg;
    assign out_valid = head_v_reg;
    assign out_data  = head_reg;

    always_comb
    begin
        head_next   = head_reg;
        head_v_next = head_v_reg;
        skid_next   = skid_reg;
        skid_v_next = skid_v_reg;
        if (head_free)
        begin
            if (skid_v_reg)
            begin
                head_next   = skid_reg;
                head_v_next = 1'b1;
                skid_next   = push_data;
                skid_v_next = push;
            end
            else
            begin
                head_next   = push_data;
                head_v_next = push;
            end
        end
        else if (push)
        begin
            skid_next   = push_data;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            head_v_reg <= head_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> head_v_reg)
        else $error("skid entry held with an empty output register");

    a_push_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !head_v_reg) |=> (head_v_reg && head_reg == $past(push_data)))
        else $error("request into empty buffer not presented");

    a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && !pop) |=> (skid_v_reg && $stable(skid_reg)))
        else $error("waiting skid entry lost");

endmodule

// File: rtl/nec_ir_frame_transmitter_top.sv
// nec_ir_frame_transmitter_top: nec infrared frame transmitter, top level
// depends on nec_tx_pkg, nec_tx_regs, nec_tx_seq, nec_tx_obuf
//
// usage:
//   input channel (in_valid/in_stall): action=1 starts a frame with address and command,
//   action=0 is one microsecond tick. a start while a frame is running is ignored.
//   output channel (out_valid/out_stall): exactly one result per request, in order:
//   pin_level, busy_res, frame_done, start_taken.
//   timing registers sit on the apb port (byte address 4*index, pready always high);
//   write them only while no request is outstanding.
// throughput: one request per cycle while in_stall is low, set by the single-pass
//   next-state logic of the frame sequencer and the output register; each result is
//   registered in the output buffer before it appears on out_valid.
// stall: results queue in a two-entry buffer (output register plus skid); in_stall
//   rises, registered, once both entries hold results, so the input keeps moving
//   for one more request after the receiver stops.
// reset: registers return to their default nec timing, the sequencer goes idle and
//   the result buffer empties.
module nec_ir_frame_transmitter_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nec_tx_pkg::APB_AW-1:0]    paddr,
    input  logic [nec_tx_pkg::APB_DW-1:0]    pwdata,
    output logic [nec_tx_pkg::APB_DW-1:0]    prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic [15:0]                      address,
    input  logic [7:0]                       command,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             pin_level,
    output logic                             busy_res,
    output logic                             frame_done,
    output logic                             start_taken
);

    nec_tx_pkg::cfg_t    cfg;
    nec_tx_pkg::result_t seq_res;
    nec_tx_pkg::result_t out_res;
    logic                accept;
    logic                full;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    nec_tx_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nec_tx_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .action  (action),
        .address (address),
        .command (command),
        .cfg     (cfg),
        .res     (seq_res)
    );

    nec_tx_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (seq_res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_res)
    );

    assign pin_level   = out_res.pin_level;
    assign busy_res    = out_res.busy_res;
    assign frame_done  = out_res.frame_done;
    assign start_taken = out_res.start_taken;

endmodule
